>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared sizes, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS     = 80;
   localparam int ROWS        = 25;
   localparam int CELL_COUNT  = COLUMNS * ROWS;
   localparam int SCROLL_SPAN = (ROWS - 1) * COLUMNS;   // cells moved by a scroll

   localparam int ADDR_W = 11;   // linear cell index
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CELL_W = 16;   // attribute:character
   localparam int CHAR_W = 8;
   localparam int ACT_W  = 2;
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);

   localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h0F;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_PUT   = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_READ  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CLEAR  = 4'b0010,
      ST_READ   = 4'b0100,
      ST_SCROLL = 4'b1000
   } state_type;

endpackage

>>> rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 2000,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];   // old data on a same-cycle write
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/text_console_writer_unit.sv
// ----------------------------------------------------------------------------
// text_console_writer_unit
// 80x25 text console: cell store in RAM, cursor, scroll and clear sequencer.
// ----------------------------------------------------------------------------
// Usage
//  - req_* carries one transaction: action (put, clear, read), char_code and
//    read_address. rsp_* returns one transaction per request: cursor position,
//    column, row, and cell_data (the cell on a read, 0 otherwise).
//  - csr_write_* sets the attribute byte; write it only while idle.
//  - Put without scroll and unused action: a new request every cycle while
//    the response is drained. Read: one RAM read, then registered data; the
//    next request waits for it. Put that scrolls: a pipelined row-shift walk
//    through the single RAM write port, one cell a cycle. Clear: one cell
//    write a cycle.
//  - Response of put/clear is posted at acceptance; requests wait until the
//    walk is done, so later reads see the finished store.
//  - Reset: cursor homes, attribute goes to 0x0F, and a clearing pass of
//    CELL_COUNT cells fills the store with blanks; req_ready stays low
//    during it. CSR writes are ignored only while reset is asserted.
//  - rsp is one output register: a new request is taken while it is empty
//    or being drained; a stalled receiver holds off further requests.
// ----------------------------------------------------------------------------
module text_console_writer_unit
   import tcw_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [ACT_W-1:0]  req_action,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [ADDR_W-1:0] req_read_address,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_cursor_position,
   output logic [COL_W-1:0]  rsp_cursor_column,
   output logic [ROW_W-1:0]  rsp_cursor_row,
   output logic [CELL_W-1:0] rsp_cell_data,
   // attribute register
   input  logic              csr_write_enable,
   input  logic [CHAR_W-1:0] csr_write_data
);

   // control state
   state_type state_ff, state_in;
   cnt_type   cnt_ff, cnt_in;          // walk index for clear and scroll
   col_type   col_ff, col_in;
   row_type   row_ff, row_in;
   char_type  attr_ff;
   cell_type  clear_data_ff, clear_data_in;
   logic      read_oob_ff, read_oob_in;

   // response register
   logic      rsp_valid_ff, rsp_valid_in;
   addr_type  rsp_pos_ff, rsp_pos_in;
   col_type   rsp_col_ff, rsp_col_in;
   row_type   rsp_row_ff, rsp_row_in;
   cell_type  rsp_cell_ff, rsp_cell_in;

   // RAM port
   logic      ram_we;
   addr_type  ram_waddr;
   cell_type  ram_wdata;
   addr_type  ram_raddr;
   cell_type  ram_rdata;

   // datapath helpers
   logic      req_accept;
   addr_type  here;
   cell_type  blank;
   col_type   col_next;
   row_type   row_next;
   logic      row_wrap;

   assign req_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_accept = req_valid && req_ready;
   assign blank      = {attr_ff, CH_SPACE};
   assign here       = ADDR_W'(row_ff * COLUMNS) + ADDR_W'(col_ff);

   // Cursor update of a put; a row past the bottom means a scroll.
   always_comb begin
      col_next = col_ff;
      row_next = row_ff;
      if (req_char_code == CH_NEWLINE) begin
         col_next = '0;
         row_next = row_ff + ROW_W'(1);
      end else if (req_char_code == CH_BACKSPACE) begin
         if (col_ff != '0) begin
            col_next = col_ff - COL_W'(1);
         end
      end else if (col_ff == COL_W'(COLUMNS - 1)) begin
         col_next = '0;
         row_next = row_ff + ROW_W'(1);
      end else begin
         col_next = col_ff + COL_W'(1);
      end
      row_wrap = (row_next == ROW_W'(ROWS));
      if (row_wrap) begin
         row_next = ROW_W'(ROWS - 1);
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      clear_data_in = clear_data_ff;
      read_oob_in   = read_oob_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pos_in    = rsp_pos_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_cell_in   = rsp_cell_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = '0;
      ram_raddr     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               // default response: cursor unchanged, no cell data
               rsp_valid_in = 1'b1;
               rsp_pos_in   = here;
               rsp_col_in   = col_ff;
               rsp_row_in   = row_ff;
               rsp_cell_in  = '0;
               case (action_type'(req_action))
                  ACT_PUT: begin
                     if (req_char_code == CH_BACKSPACE) begin
                        if (col_ff != '0) begin
                           ram_we    = 1'b1;
                           ram_waddr = here - ADDR_W'(1);
                           ram_wdata = blank;
                        end
                     end else if (req_char_code != CH_NEWLINE) begin
                        ram_we    = 1'b1;
                        ram_waddr = here;
                        ram_wdata = {attr_ff, req_char_code};
                     end
                     col_in     = col_next;
                     row_in     = row_next;
                     rsp_pos_in = ADDR_W'(row_next * COLUMNS) + ADDR_W'(col_next);
                     rsp_col_in = col_next;
                     rsp_row_in = row_next;
                     if (row_wrap) begin
                        state_in = ST_SCROLL;
                        cnt_in   = '0;
                     end
                  end
                  ACT_CLEAR: begin
                     col_in        = '0;
                     row_in        = '0;
                     rsp_pos_in    = '0;
                     rsp_col_in    = '0;
                     rsp_row_in    = '0;
                     clear_data_in = blank;
                     cnt_in        = '0;
                     state_in      = ST_CLEAR;
                  end
                  ACT_READ: begin
                     // response waits in ST_READ for the registered RAM data
                     rsp_valid_in = 1'b0;
                     read_oob_in  = (req_read_address >= ADDR_W'(CELL_COUNT));
                     ram_raddr    = read_oob_in ? '0 : req_read_address;
                     state_in     = ST_READ;
                  end
                  default: ;
               endcase
            end
         end

         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = here;
            rsp_col_in   = col_ff;
            rsp_row_in   = row_ff;
            rsp_cell_in  = read_oob_ff ? '0 : ram_rdata;
            state_in     = ST_IDLE;
         end

         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[ADDR_W-1:0];
            ram_wdata = clear_data_ff;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELL_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_SCROLL: begin
            // read cell cnt+COLUMNS, write the previous read one row up;
            // cells of the bottom row take the blank instead
            if (cnt_ff < CNT_W'(SCROLL_SPAN)) begin
               ram_raddr = ADDR_W'(cnt_ff + CNT_W'(COLUMNS));
            end
            if (cnt_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = ADDR_W'(cnt_ff - CNT_W'(1));
               ram_wdata = (cnt_ff > CNT_W'(SCROLL_SPAN)) ? blank : ram_rdata;
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELL_COUNT)) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         attr_ff       <= ATTR_RESET;
         clear_data_ff <= {ATTR_RESET, CH_SPACE};
         read_oob_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         clear_data_ff <= clear_data_in;
         read_oob_ff   <= read_oob_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            attr_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff  <= rsp_pos_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_cell_ff <= rsp_cell_in;
   end

   tcw_ram #(
      .DATA_W (CELL_W),
      .DEPTH  (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cursor_column   = rsp_col_ff;
   assign rsp_cursor_row      = rsp_row_ff;
   assign rsp_cell_data       = rsp_cell_ff;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_console_writer_unit. A queue-fed driver sends
// put, clear, read and unused-code transactions in bursts with random gaps.
// A monitor predicts every response from a shadow of the cell store, the
// cursor and the attribute register, and compares it field by field. The
// attribute is rewritten between phases, with 0x00 and 0xFF among the values.
// ----------------------------------------------------------------------------
module testbench;
   import tcw_pkg::*;

   // One request transaction and one response transaction, at port widths.
   typedef struct packed {
      action_type action;
      char_type   ch;
      addr_type   addr;
   } console_cmd_type;

   typedef struct packed {
      addr_type pos;
      col_type  col;
      row_type  row;
      cell_type data;
   } cursor_report_type;

   // Receiver pacing modes.
   typedef enum logic [1:0] {
      PACE_OPEN    = 2'd0,   // always ready
      PACE_COIN    = 2'd1,   // ready on a coin flip
      PACE_QUARTER = 2'd2,   // ready one cycle in four
      PACE_SPARSE  = 2'd3    // stalls now and then
   } pace_kind_type;

   // A scroll or clear walk keeps the store busy after its response is out;
   // wait this long before touching the attribute or ending the run.
   localparam int SETTLE_CYCLES = CELL_COUNT + 100;
   localparam int RANDOM_ITEMS  = 450;
   localparam int PHASE_COUNT   = 5;
   // Slowest correct run: about 650 transactions, each a full scroll walk
   // plus a long gap and a long stall, plus the clearing pass after reset
   // and the pauses between phases: about 5.6 ms. Taken five times over.
   localparam longint RUN_LIMIT_NS = 64'd30_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [ACT_W-1:0]  req_action = '0;
   logic [CHAR_W-1:0] req_char_code = '0;
   logic [ADDR_W-1:0] req_read_address = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [ADDR_W-1:0] rsp_cursor_position;
   logic [COL_W-1:0]  rsp_cursor_column;
   logic [ROW_W-1:0]  rsp_cursor_row;
   logic [CELL_W-1:0] rsp_cell_data;
   logic              csr_write_enable = 1'b0;
   logic [CHAR_W-1:0] csr_write_data = '0;

   text_console_writer_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_char_code       (req_char_code),
      .req_read_address    (req_read_address),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cursor_column   (rsp_cursor_column),
      .rsp_cursor_row      (rsp_cursor_row),
      .rsp_cell_data       (rsp_cell_data),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #2 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow console: cell store, cursor and attribute
   // ---------------------------------------------------------------------
   cell_type screen_img [CELL_COUNT];
   col_type  cur_col;
   row_type  cur_row;
   char_type attr_shadow;

   console_cmd_type   pending_cmds [$];
   cursor_report_type expected_reports [$];

   int  issued_count   = 0;   // transactions handed to the port
   int  answered_count = 0;   // responses matched to a prediction
   int  counted_items  = 0;   // queued transactions, unused codes excluded
   int  fault_count    = 0;
   logic req_taken = 1'b0;    // request accepted at the last rising edge

   function automatic void blank_screen();
      foreach (screen_img[i])
         screen_img[i] = {attr_shadow, CH_SPACE};
   endfunction

   // Applies one accepted transaction to the shadow and returns the response
   // the block owes for it.
   function automatic cursor_report_type console_step(console_cmd_type cmd);
      cursor_report_type r;
      int here;
      r.data = '0;
      here = int'(cur_row) * COLUMNS + int'(cur_col);
      case (cmd.action)
         ACT_PUT: begin
            if (cmd.ch == CH_NEWLINE) begin
               cur_col = '0;
               cur_row = cur_row + 1'b1;
            end else if (cmd.ch == CH_BACKSPACE) begin
               // nothing happens at the left margin
               if (cur_col != 0) begin
                  cur_col = cur_col - 1'b1;
                  screen_img[here - 1] = {attr_shadow, CH_SPACE};
               end
            end else begin
               screen_img[here] = {attr_shadow, cmd.ch};
               cur_col = cur_col + 1'b1;
            end
            // wrap past the last column
            if (int'(cur_col) >= COLUMNS) begin
               cur_col = '0;
               cur_row = cur_row + 1'b1;
            end
            // past the last row: shift everything up one row, blank the bottom
            if (int'(cur_row) >= ROWS) begin
               for (int i = 0; i < SCROLL_SPAN; i++)
                  screen_img[i] = screen_img[i + COLUMNS];
               for (int i = SCROLL_SPAN; i < CELL_COUNT; i++)
                  screen_img[i] = {attr_shadow, CH_SPACE};
               cur_row = row_type'(ROWS - 1);
            end
         end
         ACT_CLEAR: begin
            blank_screen();
            cur_col = '0;
            cur_row = '0;
         end
         ACT_READ: begin
            // addresses past the store read as zero
            if (int'(cmd.addr) < CELL_COUNT)
               r.data = screen_img[cmd.addr];
         end
         default: ;   // unused code leaves everything alone
      endcase
      r.pos = addr_type'(int'(cur_row) * COLUMNS + int'(cur_col));
      r.col = cur_col;
      r.row = cur_row;
      return r;
   endfunction

   task automatic note_fault(string msg);
      fault_count++;
      if (fault_count <= 10)
         $display("[%0t] %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------------
   // Monitor: checks responses, predicts on every accepted request.
   // Response side first so a same-edge accept never shadows the front.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : response_monitor
      cursor_report_type seen;
      cursor_report_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            seen.pos  = rsp_cursor_position;
            seen.col  = rsp_cursor_column;
            seen.row  = rsp_cursor_row;
            seen.data = rsp_cell_data;
            if (expected_reports.size() == 0) begin
               note_fault($sformatf("response with none pending: pos %0d col %0d row %0d data %h",
                                    seen.pos, seen.col, seen.row, seen.data));
            end else begin
               want = expected_reports.pop_front();
               answered_count++;
               if (seen.pos !== want.pos || seen.col !== want.col ||
                   seen.row !== want.row || seen.data !== want.data)
                  note_fault($sformatf({"response mismatch: expected pos %0d col %0d row %0d ",
                                        "data %h, got pos %0d col %0d row %0d data %h"},
                                       want.pos, want.col, want.row, want.data,
                                       seen.pos, seen.col, seen.row, seen.data));
            end
         end
         if (req_valid && req_ready)
            expected_reports.push_back(console_step('{action: action_type'(req_action),
                                                      ch:     req_char_code,
                                                      addr:   req_read_address}));
      end
   end

   // ---------------------------------------------------------------------
   // Driver: sends pending transactions in bursts with random gaps between.
   // Valid holds with a stable payload until the transaction is taken.
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(negedge clock) begin : request_driver
      console_cmd_type cmd;
      if (!reset && !(req_valid && !req_taken)) begin
         if (burst_left == 0 && gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            if (burst_left == 0)
               burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 12);
            cmd = pending_cmds.pop_front();
            issued_count++;
            req_action       <= cmd.action;
            req_char_code    <= cmd.ch;
            req_read_address <= cmd.addr;
            req_valid        <= 1'b1;
            burst_left = burst_left - 1;
            if (burst_left == 0)
               case ($urandom_range(0, 3))
                  0:       gap_left = 0;
                  1:       gap_left = $urandom_range(1, 3);
                  2:       gap_left = $urandom_range(4, 20);
                  default: gap_left = 1;
               endcase
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: ready follows a pacing mode, redrawn each time its random hold
   // count runs out, so stalls land on single cycles, on walks and on bursts alike.
   // ---------------------------------------------------------------------
   pace_kind_type pace_mode = PACE_OPEN;
   int            pace_left = 0;
   int            pace_tick = 0;

   always @(negedge clock) begin : response_pacer
      logic go;
      if (pace_left == 0) begin
         pace_mode = pace_kind_type'($urandom_range(0, 3));
         pace_left = $urandom_range(50, 400);
      end
      pace_left = pace_left - 1;
      pace_tick = pace_tick + 1;
      case (pace_mode)
         PACE_OPEN:    go = 1'b1;
         PACE_COIN:    go = $urandom_range(0, 1);
         PACE_QUARTER: go = (pace_tick[1:0] == 2'b00);
         default:      go = ($urandom_range(0, 7) != 0);
      endcase
      rsp_ready <= go;
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_cmd(action_type a, char_type c, addr_type ad);
      pending_cmds.push_back('{action: a, ch: c, addr: ad});
      if (a != ACT_NONE)
         counted_items++;
   endtask

   // Any byte except the two control codes.
   function automatic char_type pick_glyph();
      char_type c;
      do
         c = char_type'($urandom_range(0, 255));
      while (c == CH_NEWLINE || c == CH_BACKSPACE);
      return c;
   endfunction

   // Read addresses lean toward the bottom rows, where scrolls land, the top
   // row, and toward the end of the store and the range past it.
   function automatic addr_type pick_address();
      case ($urandom_range(0, 6))
         0, 1, 2: return addr_type'($urandom_range(0, CELL_COUNT - 1));
         3, 4:    return addr_type'($urandom_range((ROWS - 3) * COLUMNS, CELL_COUNT - 1));
         5:       return addr_type'($urandom_range(0, COLUMNS - 1));
         default: return addr_type'($urandom_range(CELL_COUNT - 10, (1 << ADDR_W) - 1));
      endcase
   endfunction

   function automatic addr_type any_address();
      return addr_type'($urandom_range(0, (1 << ADDR_W) - 1));
   endfunction

   // Wait until every handed-out transaction has been answered, then let
   // any scroll or clear walk run out.
   task automatic settle_console();
      while (pending_cmds.size() != 0 || answered_count != issued_count)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_attribute(char_type v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      attr_shadow = v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed text: short and overlong lines, newline runs that
   // push the cursor off the bottom, backspaces, reads; the rest raw bytes,
   // unused codes and the odd clear.
   task automatic queue_random(int amount);
      int goal;
      int n;
      goal = counted_items + amount;
      while (counted_items < goal) begin
         case ($urandom_range(0, 99)) inside
            [0:39]: begin
               n = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 100)
                                               : $urandom_range(0, 20);
               repeat (n) queue_cmd(ACT_PUT, pick_glyph(), any_address());
               if ($urandom_range(0, 3) != 0)
                  queue_cmd(ACT_PUT, CH_NEWLINE, any_address());
            end
            [40:54]:
               repeat ($urandom_range(1, 30))
                  queue_cmd(ACT_PUT, CH_NEWLINE, any_address());
            [55:67]: begin
               repeat ($urandom_range(0, 5)) queue_cmd(ACT_PUT, pick_glyph(), any_address());
               repeat ($urandom_range(1, 8)) queue_cmd(ACT_PUT, CH_BACKSPACE, any_address());
            end
            [68:87]:
               repeat ($urandom_range(1, 4))
                  queue_cmd(ACT_READ, char_type'($urandom_range(0, 255)), pick_address());
            [88:92]:
               queue_cmd(ACT_PUT, char_type'($urandom_range(0, 255)), any_address());
            [93:96]:
               queue_cmd(ACT_NONE, char_type'($urandom_range(0, 255)), any_address());
            default:
               queue_cmd(ACT_CLEAR, char_type'($urandom_range(0, 255)), any_address());
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence: reset, directed checks, then random phases, each under a new
   // attribute value.
   // ---------------------------------------------------------------------
   initial begin : stimulus
      char_type phase_attr [PHASE_COUNT];
      phase_attr[0] = 8'h00;
      phase_attr[1] = 8'hFF;
      phase_attr[2] = char_type'($urandom_range(0, 255));
      phase_attr[3] = 8'h5A;
      phase_attr[4] = char_type'($urandom_range(0, 255));

      attr_shadow = ATTR_RESET;
      cur_col     = '0;
      cur_row     = '0;
      blank_screen();

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed part, under the reset attribute.
      queue_cmd(ACT_READ, 8'hFF, '0);                          // reset blank
      queue_cmd(ACT_READ, 8'h00, addr_type'(CELL_COUNT - 1));  // last cell
      queue_cmd(ACT_READ, 8'h55, addr_type'(CELL_COUNT));      // just past the store
      queue_cmd(ACT_READ, 8'hAA, '1);                          // far past the store
      queue_cmd(ACT_PUT, CH_BACKSPACE, '0);                    // backspace at margin
      queue_cmd(ACT_PUT, 8'h00, '1);
      queue_cmd(ACT_PUT, 8'hFF, '0);
      queue_cmd(ACT_PUT, 8'h41, addr_type'(11'h400));
      queue_cmd(ACT_PUT, CH_BACKSPACE, '0);                    // blanks the 'A'
      queue_cmd(ACT_READ, 8'h00, addr_type'(0));
      queue_cmd(ACT_READ, 8'h00, addr_type'(1));
      queue_cmd(ACT_READ, 8'h00, addr_type'(2));
      queue_cmd(ACT_NONE, 8'hFF, '1);                          // unused code
      queue_cmd(ACT_PUT, CH_NEWLINE, '0);
      queue_cmd(ACT_PUT, CH_SPACE, '0);
      queue_cmd(ACT_READ, 8'h00, addr_type'(COLUMNS));
      queue_cmd(ACT_CLEAR, 8'hFF, '1);
      queue_cmd(ACT_READ, 8'h00, addr_type'(0));
      queue_cmd(ACT_READ, 8'h00, addr_type'(11'h400));
      settle_console();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_attribute(phase_attr[ph]);
         queue_random(RANDOM_ITEMS / PHASE_COUNT);
         settle_console();
      end

      if (fault_count == 0 && expected_reports.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Hang guard.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("FAILURE");
      $finish;
   end

endmodule
